/* sv/uwms_pkg.sv */
// Package for the distinct-value window sum block.
// Holds the sizing constants and the types shared by the RTL, the interfaces and the checker.
// No dependencies.
package uwms_pkg;

	// Sizing of keys, positions and sums.
	localparam int VALUE_BITS = 10;
	localparam int MAX_LEN    = 1024;
	localparam int KEY_DEPTH  = 2 ** VALUE_BITS;
	localparam int POS_BITS   = $clog2(MAX_LEN);
	localparam int SUM_BITS   = 20;
	localparam int EPOCH_BITS = 8;

	// Position count at which further words are dropped.
	localparam logic [POS_BITS:0] LEN_LIMIT = (POS_BITS + 1)'(MAX_LEN);

	// Epoch zero marks a cleared entry, so live epochs run from one to all ones.
	localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
	localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = {EPOCH_BITS{1'b1}};
	localparam logic [EPOCH_BITS-1:0] EPOCH_CLEAR = '0;

	// One entry of the last-seen memory.
	typedef struct packed {
		logic [EPOCH_BITS-1:0] epoch;
		logic [POS_BITS-1:0]   pos;
	} lp_entry_t;

	// One result word as it waits in the output queue.
	typedef struct packed {
		logic [SUM_BITS-1:0] window_sum;
		logic [SUM_BITS-1:0] best_sum;
		logic                overflow;
		logic                done_res;
	} res_t;

	// Fill status of the output queue.
	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

endpackage

/* sv/uwms_in_if.sv */
// Input channel of the distinct-value window sum block.
// Carries valid, ready and the input word; depends on uwms_pkg.
interface uwms_in_if import uwms_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;
	logic                  last_item;

	modport source(output valid, value, last_item, input ready);
	modport sink(input valid, value, last_item, output ready);
endinterface

/* sv/uwms_out_if.sv */
// Result channel of the distinct-value window sum block.
// Carries valid, ready and the result word; depends on uwms_pkg.
interface uwms_out_if import uwms_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SUM_BITS-1:0] window_sum;
	logic [SUM_BITS-1:0] best_sum;
	logic                overflow;
	logic                done_res;

	modport source(output valid, window_sum, best_sum, overflow, done_res, input ready);
	modport sink(input valid, window_sum, best_sum, overflow, done_res, output ready);
endinterface

/* sv/unique_window_max_sum_top.sv */
// Top level of the distinct-value window sum block.
// Depends on uwms_pkg, uwms_in_if, uwms_out_if, uwms_ram and uwms_outq.
//
//   channel  | interface   | direction | word
//   ---------+-------------+-----------+-----------------------------------------------
//   item     | uwms_in_if  | in        | value, last_item
//   result   | uwms_out_if | out       | window_sum, best_sum, overflow, done_res
//
// A word is taken only while no earlier word sits in stage one; the last-seen memory read and the
// dependent prefix memory read at the new window start are each registered memory reads.
// A result passes stage one and stage two and then enters the two-entry output queue.
// After reset, and after every 255th sequence, a clearing pass sweeps
// the last-seen memory one entry a cycle; item.ready stays low meanwhile.
// A stalled result channel fills the queue and then holds item.ready low.
module unique_window_max_sum_top import uwms_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	uwms_in_if.sink    item,
	uwms_out_if.source result
);

	// Sequence state.
	logic [POS_BITS:0]       pos_q;
	logic [POS_BITS-1:0]     ws_q;
	logic [SUM_BITS-1:0]     rp_q;
	logic [SUM_BITS-1:0]     best_q;
	logic [SUM_BITS-1:0]     wsum_q;
	logic                    ovf_q;
	logic [EPOCH_BITS-1:0]   epoch_q;
	logic                    clr_q;
	logic [VALUE_BITS-1:0]   clr_addr_q;

	// Pipeline registers.
	logic                    valid_s1;
	logic [VALUE_BITS-1:0]   key_s1;
	logic                    last_s1;
	logic                    valid_s2;
	logic                    last_s2;
	logic                    skip_s2;
	logic                    ovf_s2;
	logic                    fwd_s2;
	logic [VALUE_BITS-1:0]   key_s2;
	logic [SUM_BITS-1:0]     rp_s2;

	// Memory ports.
	logic                    lp_we;
	logic [VALUE_BITS-1:0]   lp_waddr;
	lp_entry_t               lp_wdata;
	lp_entry_t               lp_rdata;
	logic                    pf_we;
	logic [SUM_BITS-1:0]     pf_rdata;

	// Stage one and stage two logic.
	logic                    acc;
	logic                    ovf_item;
	logic                    hit;
	logic [POS_BITS-1:0]     ws_new;
	logic [SUM_BITS-1:0]     rp_new;
	logic                    fwd;
	logic [SUM_BITS-1:0]     wsum_calc;
	logic [SUM_BITS-1:0]     best_new;
	res_t                    res;
	qstat_t                  qstat;

	// A word is taken when no clearing pass runs, no word sits in stage one and the queue has room for it.
	assign item.ready = !clr_q && !valid_s1 && (qstat.empty || (!qstat.full && !valid_s2));
	assign acc        = item.valid && item.ready;

	// Stage one: window start from the last-seen entry, which the read at acceptance returned.
	assign ovf_item = (pos_q == LEN_LIMIT);
	assign hit      = (lp_rdata.epoch == epoch_q) && (lp_rdata.pos >= ws_q);
	assign ws_new   = hit ? POS_BITS'(lp_rdata.pos + 1'b1) : ws_q;
	assign rp_new   = rp_q + SUM_BITS'(key_s1);
	// The prefix at the current position is written this cycle, so it is not yet in memory.
	assign fwd      = (ws_new == pos_q[POS_BITS-1:0]);

	// Last-seen memory writes, shared with the clearing pass.
	assign lp_we          = clr_q || (valid_s1 && !ovf_item);
	assign lp_waddr       = clr_q ? clr_addr_q : key_s1;
	assign lp_wdata.epoch = clr_q ? EPOCH_CLEAR : epoch_q;
	assign lp_wdata.pos   = clr_q ? '0 : pos_q[POS_BITS-1:0];

	assign pf_we = valid_s1 && !ovf_item;

	uwms_ram #(
		.WIDTH($bits(lp_entry_t)),
		.DEPTH(KEY_DEPTH)
	) u_lp_ram (
		.clk  (clk),
		.we   (lp_we),
		.waddr(lp_waddr),
		.wdata(lp_wdata),
		.raddr(item.value),
		.rdata(lp_rdata)
	);

	uwms_ram #(
		.WIDTH(SUM_BITS),
		.DEPTH(MAX_LEN)
	) u_pf_ram (
		.clk  (clk),
		.we   (pf_we),
		.waddr(pos_q[POS_BITS-1:0]),
		.wdata(rp_q),
		.raddr(ws_new),
		.rdata(pf_rdata)
	);

	// Stage two: window sum from the prefix read and the best sum so far.
	assign wsum_calc = fwd_s2 ? SUM_BITS'(key_s2) : (rp_s2 - pf_rdata);
	assign best_new  = (!skip_s2 && (wsum_calc > best_q)) ? wsum_calc : best_q;

	assign res.window_sum = skip_s2 ? wsum_q : wsum_calc;
	assign res.best_sum   = best_new;
	assign res.overflow   = ovf_s2;
	assign res.done_res   = last_s2;

	// Control and sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			pos_q      <= '0;
			ws_q       <= '0;
			rp_q       <= '0;
			best_q     <= '0;
			wsum_q     <= '0;
			ovf_q      <= 1'b0;
			epoch_q    <= EPOCH_FIRST;
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else begin
			valid_s1 <= acc;
			valid_s2 <= valid_s1;

			// Clearing pass over the last-seen memory.
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == {VALUE_BITS{1'b1}}) begin
					clr_q <= 1'b0;
				end
			end

			// Stage one updates the position, window start and running prefix.
			if (valid_s1) begin
				if (ovf_item) begin
					ovf_q <= 1'b1;
				end else begin
					ws_q  <= ws_new;
					rp_q  <= rp_new;
					pos_q <= pos_q + 1'b1;
				end
				if (last_s1) begin
					pos_q <= '0;
					ws_q  <= '0;
					rp_q  <= '0;
					ovf_q <= 1'b0;
					if (epoch_q == EPOCH_LAST) begin
						epoch_q    <= EPOCH_FIRST;
						clr_q      <= 1'b1;
						clr_addr_q <= '0;
					end else begin
						epoch_q <= epoch_q + 1'b1;
					end
				end
			end

			// Stage two updates the best sum and the last window sum.
			if (valid_s2) begin
				best_q <= best_new;
				if (!skip_s2) begin
					wsum_q <= wsum_calc;
				end
				if (last_s2) begin
					best_q <= '0;
					wsum_q <= '0;
				end
			end
		end
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (acc) begin
			key_s1  <= item.value;
			last_s1 <= item.last_item;
		end
		if (valid_s1) begin
			last_s2 <= last_s1;
			skip_s2 <= ovf_item;
			ovf_s2  <= ovf_q || ovf_item;
			fwd_s2  <= fwd;
			key_s2  <= key_s1;
			rp_s2   <= rp_new;
		end
	end

	uwms_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (valid_s2),
		.din   (res),
		.stat  (qstat),
		.result(result)
	);

endmodule

/* sv/uwms_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// A read of the address being written returns the old contents. No dependencies.
module uwms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/uwms_outq.sv */
// Two-entry output queue that decouples the result channel from the pipeline.
// Depends on uwms_pkg and uwms_out_if.
module uwms_outq import uwms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  res_t        din,
	output qstat_t      stat,
	uwms_out_if.source  result
);

	res_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;
	res_t       head;

	assign pop  = result.valid && result.ready;
	assign head = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= din;
		end
	end

	assign stat.empty = (cnt_q == 2'd0);
	assign stat.full  = (cnt_q == 2'd2);

	assign result.valid      = (cnt_q != 2'd0);
	assign result.window_sum = head.window_sum;
	assign result.best_sum   = head.best_sum;
	assign result.overflow   = head.overflow;
	assign result.done_res   = head.done_res;

endmodule

/* sv/uwms_chk.sv */
// Port-level checker for the distinct-value window sum block, bound to the top level.
// Depends on uwms_pkg and unique_window_max_sum_top.
module uwms_chk import uwms_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic                result_valid,
	input logic                result_ready,
	input logic [SUM_BITS-1:0] window_sum,
	input logic [SUM_BITS-1:0] best_sum,
	input logic                overflow,
	input logic                done_res
);

	// A taken word occupies the first stage, so the next cycle takes none.
	a_one_word_per_two: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
	else $error("item taken in two consecutive cycles");

	// The best sum never falls below the window sum that goes with it.
	a_best_covers_window: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> best_sum >= window_sum)
	else $error("best_sum below window_sum");

	// A stalled result word holds.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(window_sum)
			&& $stable(best_sum) && $stable(overflow) && $stable(done_res))
	else $error("stalled result word changed");

endmodule

bind unique_window_max_sum_top uwms_chk u_uwms_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_valid  (item.valid),
	.item_ready  (item.ready),
	.result_valid(result.valid),
	.result_ready(result.ready),
	.window_sum  (result.window_sum),
	.best_sum    (result.best_sum),
	.overflow    (result.overflow),
	.done_res    (result.done_res)
);

/* test/uwms_window_checker.sv */
// Checker for the distinct-value window sum block: watches both channels and predicts results.
// Keeps its own copy of the last-seen table, prefix sums and running totals.
// Depends on uwms_pkg, uwms_in_if and uwms_out_if.
module uwms_window_checker import uwms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	uwms_in_if          item,
	uwms_out_if         result,
	output int unsigned fail_total,
	output int unsigned words_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_LIMIT = 10;

	// Predicted state of the current sequence.
	logic [POS_BITS-1:0] seen_at [KEY_DEPTH];
	logic                seen_live [KEY_DEPTH];
	logic [SUM_BITS-1:0] prefix_at [MAX_LEN];
	int unsigned         seq_pos;
	int unsigned         win_start;
	logic [SUM_BITS-1:0] run_prefix;
	logic [SUM_BITS-1:0] best_run;
	logic                dropped;

	// Result words still owed by the block, oldest first.
	res_t        expected_sums [$];
	int unsigned fails;
	int unsigned result_index;

	// Forget the sequence: table marks, position, window and totals.
	function automatic void clear_run();
		for (int k = 0; k < KEY_DEPTH; k++)
			seen_live[k] = 1'b0;
		seq_pos    = 0;
		win_start  = 0;
		run_prefix = '0;
		best_run   = '0;
		dropped    = 1'b0;
	endfunction

	// Advance the window by one value and form the result word it produces.
	function automatic res_t window_step(input logic [VALUE_BITS-1:0] v, input logic last);
		res_t                r;
		logic [SUM_BITS-1:0] wsum;
		if (seq_pos >= MAX_LEN) begin
			// Sequence too long: the word is dropped and the totals are repeated.
			dropped = 1'b1;
			wsum = (win_start >= MAX_LEN) ? '0 : run_prefix - prefix_at[win_start];
		end else begin
			prefix_at[seq_pos] = run_prefix;
			// A repeat inside the window pushes the start just past its earlier copy.
			if (seen_live[v] && 32'(seen_at[v]) >= win_start)
				win_start = 32'(seen_at[v]) + 1;
			seen_at[v]   = POS_BITS'(seq_pos);
			seen_live[v] = 1'b1;
			run_prefix   = run_prefix + SUM_BITS'(v);
			wsum = run_prefix - prefix_at[win_start];
			if (wsum > best_run)
				best_run = wsum;
			seq_pos++;
		end
		r.window_sum = wsum;
		r.best_sum   = best_run;
		r.overflow   = dropped;
		r.done_res   = last;
		if (last)
			clear_run();
		return r;
	endfunction

	// Predict on every accepted input word, compare on every accepted result word.
	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		res_t predicted;
		if (!arst_n) begin
			clear_run();
			expected_sums.delete();
			fails = 0;
			result_index = 0;
		end else begin
			if (item.valid && item.ready) begin
				predicted = window_step(item.value, item.last_item);
				expected_sums = {expected_sums, predicted};
			end
			if (result.valid && result.ready) begin
				got.window_sum = result.window_sum;
				got.best_sum   = result.best_sum;
				got.overflow   = result.overflow;
				got.done_res   = result.done_res;
				if (expected_sums.size() == 0) begin
					fails++;
					if (fails <= REPORT_LIMIT)
						$display({"result word %0d arrived with no input word behind it: ",
							"sum %0d best %0d ovf %b done %b"},
							result_index, got.window_sum, got.best_sum, got.overflow,
							got.done_res);
				end else begin
					want = expected_sums.pop_front();
					if (got.window_sum !== want.window_sum || got.best_sum !== want.best_sum ||
						got.overflow !== want.overflow || got.done_res !== want.done_res) begin
						fails++;
						if (fails <= REPORT_LIMIT)
							$display({"result word %0d: expected sum %0d best %0d ovf %b done %b, ",
								"got sum %0d best %0d ovf %b done %b"},
								result_index, want.window_sum, want.best_sum, want.overflow,
								want.done_res, got.window_sum, got.best_sum, got.overflow,
								got.done_res);
					end
				end
				result_index++;
			end
		end
		fail_total    <= fails;
		words_pending <= expected_sums.size();
	end

endmodule

/* test/unique_window_max_sum_top_test.sv */
// Testbench top for unique_window_max_sum_top: clock, reset, input words, back-pressure, verdict.
// Directed sequences, some short random sequences, then one sequence past the length limit.
// Depends on uwms_pkg, uwms_in_if, uwms_out_if, uwms_window_checker and the block itself.
module unique_window_max_sum_top_test import uwms_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SHORT_RUNS     = 20;
	localparam int LONG_LEN       = MAX_LEN + 8;
	localparam int QUIET_TAIL     = 200;
	localparam int HOLD_CYCLES    = 64;
	localparam int DRAIN_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 5000;

	// Directed sequences: single zero, adjacent repeat of the top value, a repeat that lies
	// before the window start, mixed extremes, alternating bit patterns, and a value that
	// was seen only in the previous sequence.
	localparam int DIR_LEN = 18;
	localparam logic [VALUE_BITS-1:0] DIR_VALUE [DIR_LEN] = '{
		0,
		1023, 1023,
		1, 2, 3, 2, 1,
		512, 1, 512, 1023, 0, 1023,
		682, 341, 682,
		341
	};
	localparam logic DIR_LAST [DIR_LEN] = '{
		1'b1,
		1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
		1'b0, 1'b0, 1'b1,
		1'b1
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        gaps_on;
	int unsigned hold_asked = 0;
	int unsigned hold_granted = 0;
	int unsigned sink_wait = 0;
	int unsigned idle_cycles = 0;
	int unsigned fail_count;
	int unsigned words_pending;

	uwms_in_if  in_ch ();
	uwms_out_if out_ch ();

	unique_window_max_sum_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (in_ch),
		.result (out_ch)
	);

	uwms_window_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.item          (in_ch),
		.result        (out_ch),
		.fail_total    (fail_count),
		.words_pending (words_pending)
	);

	// 10 ns clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Offer one word, with an occasional short gap first, and wait until it is taken.
	task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic last);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_ch.valid     <= 1'b1;
		in_ch.value     <= v;
		in_ch.last_item <= last;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Result side: short random stalls, plus a long hold-off whenever one is asked for.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (sink_wait != 0) begin
			out_ch.ready <= 1'b0;
			sink_wait--;
		end else if (hold_granted != hold_asked) begin
			hold_granted = hold_asked;
			sink_wait = HOLD_CYCLES - 1;
			out_ch.ready <= 1'b0;
		end else if (gaps_on && $urandom_range(0, 4) == 0) begin
			sink_wait = $urandom_range(0, 2);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	// Watchdog: too long without any word moving on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("no word moved for %0d cycles", idle_cycles);
			$display("unique_window_max_sum_top regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Stimulus and verdict.
	initial begin
		int unsigned           run_len;
		int unsigned           pick;
		int unsigned           stride;
		int unsigned           offset;
		logic                  narrow;
		logic [VALUE_BITS-1:0] v;

		in_ch.valid     <= 1'b0;
		in_ch.value     <= '0;
		in_ch.last_item <= 1'b0;
		gaps_on         <= 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed sequences, no gaps.
		for (int i = 0; i < DIR_LEN; i++)
			send_word(DIR_VALUE[i], DIR_LAST[i]);

		// Short sequences. Narrow value pools force repeats inside and across sequences.
		for (int s = 0; s < SHORT_RUNS; s++) begin
			gaps_on <= ($urandom_range(0, 3) != 0);
			if (s == 8)
				hold_asked <= hold_asked + 1;
			pick = $urandom_range(0, 9);
			run_len = (pick < 5) ? 1 : (pick < 9) ? $urandom_range(2, 4) : $urandom_range(5, 12);
			narrow = ($urandom_range(0, 1) != 0);
			for (int i = 0; i < run_len; i++) begin
				v = narrow ? VALUE_BITS'($urandom_range(0, 7)) : VALUE_BITS'($urandom);
				send_word(v, i == run_len - 1);
			end
		end

		// One sequence past the length limit. A mostly distinct stride walk lets the
		// window grow large; sparse small values break it up now and then.
		stride = $urandom_range(0, (KEY_DEPTH / 2) - 1) * 2 + 1;
		offset = $urandom_range(0, KEY_DEPTH - 1);
		gaps_on <= 1'b1;
		for (int i = 0; i < LONG_LEN; i++) begin
			if (i == 300)
				hold_asked <= hold_asked + 1;
			if (i == LONG_LEN - QUIET_TAIL)
				gaps_on <= 1'b0;
			if ($urandom_range(0, 15) == 0)
				v = VALUE_BITS'($urandom_range(0, 3));
			else
				v = VALUE_BITS'(i * stride + offset);
			send_word(v, i == LONG_LEN - 1);
		end
		in_ch.valid <= 1'b0;

		// Let the last results drain.
		@(posedge clk);
		while (words_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0 && words_pending == 0) begin
			$display("unique_window_max_sum_top regression: pass");
		end else begin
			$display("%0d mismatches, %0d result words outstanding", fail_count, words_pending);
			$display("unique_window_max_sum_top regression: fail");
		end
		$finish;
	end

endmodule
